// ----- hw/rtl/lzss_pkg.sv -----
// Package for the LZSS stream decompressor: window size, parse phases,
// token field constants. No dependencies.
package lzss_pkg;

  localparam int WINDOW_DEPTH   = 4096;
  localparam int PTR_W          = $clog2(WINDOW_DEPTH);
  localparam int MIN_LEN        = 3;
  localparam int LEN_W          = 5;   // holds MIN_LEN + 15
  localparam int ITEMS_PER_FLAG = 8;

  // parse phases
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_HDR3 = 3'd3;
  localparam logic [2:0] PH_FLAG = 3'd4;
  localparam logic [2:0] PH_ITEM = 3'd5;
  localparam logic [2:0] PH_HIGH = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

endpackage

// ----- hw/rtl/lzss_if.sv -----
// Valid/ready channel interfaces for the compressed input and the
// decompressed output. No dependencies.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, in_byte, stream_start, input ready);
  modport sink   (input valid, in_byte, stream_start, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  logic       bad_reference;

  modport source (output valid, out_byte, run_last, stream_done, bad_reference,
                  input ready);
  modport sink   (input valid, out_byte, run_last, stream_done, bad_reference,
                  output ready);
endinterface

// ----- hw/rtl/lzss_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Read during write to the same address returns the old data.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lzss_stream_decompressor.sv -----
// LZSS stream decompressor, 4 KiB history ring in one lzss_ram. Header
// and flag bytes: no output. Literal: byte shows in the output register
// the next cycle. Token: L bytes (L = clipped match length, up to 18), one
// byte per cycle from the ring or its write forwarding while the output is
// not stalled. Depends on lzss_pkg, lzss_if, lzss_ram. rst_n synchronous,
// active low; ring has no reset, a match before stream start yields zeros.
module lzss_stream_decompressor (
  input  logic             clk,
  input  logic             rst_n,
  lzss_in_if.sink          in_ch,
  lzss_out_if.source       out_ch
);
  import lzss_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_COPY = 1'b1;

  // Phase after an item finishes: stream end, new flag byte, or next item.
  function automatic logic [2:0] next_phase(logic [31:0] prod, logic [31:0] orig,
                                            logic [3:0] idx);
    logic [2:0] ph;
    if (prod == orig) begin
      ph = PH_DONE;
    end else if (idx >= 4'(ITEMS_PER_FLAG)) begin
      ph = PH_FLAG;
    end else begin
      ph = PH_ITEM;
    end
    return ph;
  endfunction

  // control state
  logic             state_r, state_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [31:0]      orig_r, orig_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [7:0]       tlow_r, tlow_nxt;
  // match copy
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic             mbad_r, mbad_nxt;
  logic             fwd_r, fwd_nxt;
  logic [7:0]       fwd_data_r, fwd_data_nxt;
  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_done_r, out_done_nxt;
  logic             out_bad_r, out_bad_nxt;

  // ring port
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic can_load, in_fire;

  // effective state after a stream_start restart
  logic [2:0]       e_phase;
  logic [31:0]      e_orig, e_prod;
  logic [PTR_W-1:0] e_wptr;
  logic [7:0]       e_flag;
  logic [3:0]       e_idx;

  // token decode
  logic [15:0]      token;
  logic [PTR_W:0]   match_dist;
  logic [LEN_W-1:0] len_full, len_clip;
  logic [31:0]      remain;
  logic             tok_bad;
  logic [7:0]       copy_byte;
  logic [PTR_W-1:0] rd_next;

  // Output register frees when empty or being drained this cycle.
  assign can_load = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && can_load;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign token      = {in_ch.in_byte, tlow_r};
  assign match_dist = {1'b0, token[15:4]} + (PTR_W+1)'(1);
  assign len_full   = LEN_W'(token[3:0]) + LEN_W'(MIN_LEN);
  assign remain     = orig_r - prod_r;
  assign len_clip   = (remain < 32'(len_full)) ? remain[LEN_W-1:0] : len_full;
  assign tok_bad    = 32'(match_dist) > prod_r;

  assign copy_byte = mbad_r ? 8'd0 : (fwd_r ? fwd_data_r : ram_rdata);
  assign rd_next   = rd_addr_r + PTR_W'(1);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    orig_nxt      = orig_r;
    prod_nxt      = prod_r;
    wptr_nxt      = wptr_r;
    flag_nxt      = flag_r;
    idx_nxt       = idx_r;
    tlow_nxt      = tlow_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    mbad_nxt      = mbad_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = wptr_r;
    ram_wdata     = 8'd0;
    ram_re        = 1'b0;
    ram_raddr     = rd_addr_r;

    if (in_ch.stream_start) begin
      e_phase = PH_HDR0;
      e_orig  = '0;
      e_prod  = '0;
      e_wptr  = '0;
      e_flag  = '0;
      e_idx   = '0;
    end else begin
      e_phase = phase_r;
      e_orig  = orig_r;
      e_prod  = prod_r;
      e_wptr  = wptr_r;
      e_flag  = flag_r;
      e_idx   = idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          phase_nxt = e_phase;
          orig_nxt  = e_orig;
          prod_nxt  = e_prod;
          wptr_nxt  = e_wptr;
          flag_nxt  = e_flag;
          idx_nxt   = e_idx;
          if (in_ch.stream_start) begin
            tlow_nxt = '0;
          end
          case (e_phase) inside
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
              // little-endian length assembly
              orig_nxt[{e_phase[1:0], 3'b000} +: 8] = in_ch.in_byte;
              if (e_phase == PH_HDR3) begin
                phase_nxt = (orig_nxt == '0) ? PH_DONE : PH_FLAG;
              end else begin
                phase_nxt = e_phase + 3'd1;
              end
            end
            PH_FLAG: begin
              flag_nxt  = in_ch.in_byte;
              idx_nxt   = '0;
              phase_nxt = PH_ITEM;
            end
            PH_ITEM: begin
              if (e_flag[e_idx[2:0]]) begin
                tlow_nxt  = in_ch.in_byte;
                phase_nxt = PH_HIGH;
              end else begin
                // literal: straight to ring and output register
                ram_we        = 1'b1;
                ram_waddr     = e_wptr;
                ram_wdata     = in_ch.in_byte;
                wptr_nxt      = e_wptr + PTR_W'(1);
                prod_nxt      = e_prod + 32'd1;
                out_valid_nxt = 1'b1;
                out_byte_nxt  = in_ch.in_byte;
                out_last_nxt  = 1'b1;
                out_done_nxt  = (prod_nxt == e_orig);
                out_bad_nxt   = 1'b0;
                idx_nxt       = e_idx + 4'd1;
                phase_nxt     = next_phase(prod_nxt, e_orig, idx_nxt);
              end
            end
            PH_HIGH: begin
              // token complete: issue first ring read, start the copy
              state_nxt   = S_COPY;
              cnt_nxt     = len_clip;
              mbad_nxt    = tok_bad;
              fwd_nxt     = 1'b0;
              ram_re      = 1'b1;
              ram_raddr   = wptr_r - match_dist[PTR_W-1:0];
              rd_addr_nxt = ram_raddr;
            end
            default: begin
              // finished stream: byte dropped
            end
          endcase
        end
      end
      S_COPY: begin
        if (can_load) begin
          ram_we        = 1'b1;
          ram_waddr     = wptr_r;
          ram_wdata     = copy_byte;
          wptr_nxt      = wptr_r + PTR_W'(1);
          prod_nxt      = prod_r + 32'd1;
          cnt_nxt       = cnt_r - LEN_W'(1);
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_byte;
          out_last_nxt  = (cnt_r == LEN_W'(1));
          out_done_nxt  = (prod_nxt == orig_r);
          out_bad_nxt   = mbad_r;
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
            idx_nxt   = idx_r + 4'd1;
            phase_nxt = next_phase(prod_nxt, orig_r, idx_nxt);
          end else begin
            // next read; distance one hits the entry written this cycle
            ram_re       = 1'b1;
            ram_raddr    = rd_next;
            rd_addr_nxt  = rd_next;
            fwd_nxt      = (rd_next == wptr_r);
            fwd_data_nxt = copy_byte;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HDR0;
      orig_r      <= '0;
      prod_r      <= '0;
      wptr_r      <= '0;
      flag_r      <= '0;
      idx_r       <= '0;
      tlow_r      <= '0;
      cnt_r       <= '0;
      mbad_r      <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      orig_r      <= orig_nxt;
      prod_r      <= prod_nxt;
      wptr_r      <= wptr_nxt;
      flag_r      <= flag_nxt;
      idx_r       <= idx_nxt;
      tlow_r      <= tlow_nxt;
      cnt_r       <= cnt_nxt;
      mbad_r      <= mbad_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.run_last      = out_last_r;
  assign out_ch.stream_done   = out_done_r;
  assign out_ch.bad_reference = out_bad_r;

endmodule

// ----- hw/rtl/lzss_checker.sv -----
// Port-level checks for lzss_stream_decompressor, bound to the top level.
// Depends on lzss_if through the top level's channel ports.
module lzss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_done,
  input logic       bad_reference
);

  // stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("output changed while stalled");

  // a bad reference always yields a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_reference |-> out_byte == 8'd0)
    else $error("bad reference with nonzero byte");

  // the byte that completes the stream closes its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> run_last)
    else $error("stream done on a byte that is not last of its item");

  // no input transfer while a result is held back
  a_no_in_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind lzss_stream_decompressor lzss_checker u_lzss_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .run_last      (out_ch.run_last),
  .stream_done   (out_ch.stream_done),
  .bad_reference (out_ch.bad_reference)
);
